>>> rtl/rfs_pkg.sv
package rfs_pkg;

    localparam int PREAMBLE_LEN_DEF = 20;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // command codes of the input channel
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BODY  = 2'd1;
    localparam logic [1:0] CMD_FINAL = 2'd2;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0] SYNC0         = 8'hFF;
    localparam logic [7:0] SYNC1         = 8'h00;
    localparam logic [7:0] SYNC2         = 8'h33;
    localparam logic [7:0] SYNC3         = 8'h55;
    localparam logic [7:0] SYNC4         = 8'h53;
    localparam logic [7:0] TRAILER0      = 8'h35;
    localparam logic [7:0] TRAILER1      = 8'h55;
    localparam logic [7:0] BAD_HEADER    = 8'hFF;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_BODY,
        KIND_FINAL
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic [7:0] csum;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] nib_code(input logic [3:0] nib);
        logic [7:0] code;
        case (nib)
            4'h0: code = 8'hAA;
            4'h1: code = 8'hA9;
            4'h2: code = 8'hA6;
            4'h3: code = 8'hA5;
            4'h4: code = 8'h9A;
            4'h5: code = 8'h99;
            4'h6: code = 8'h96;
            4'h7: code = 8'h95;
            4'h8: code = 8'h6A;
            4'h9: code = 8'h69;
            4'hA: code = 8'h66;
            4'hB: code = 8'h65;
            4'hC: code = 8'h5A;
            4'hD: code = 8'h59;
            4'hE: code = 8'h56;
            4'hF: code = 8'h55;
            default: code = 8'hAA;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/radio_frame_serializer.sv
// radio frame serializer
// input channel: one request per message part. s_cmd start carries the
// message type, address mask and parameter flags; body and final body
// requests carry one unencoded byte each in s_data_byte. body requests
// outside a message and undefined commands are taken and dropped.
// output channel: one frame byte per request, m_last on the last byte
// that an input request causes.
// a start request gives PREAMBLE_LEN + 7 bytes, a body byte gives 2,
// a final body byte gives 6 (coded byte, coded checksum, trailer).
// the output register issues one byte per cycle while the receiver is
// ready; the front side takes requests every cycle until the job queue
// (QUEUE_DEPTH entries) is full. the first byte of a request passes
// through the job queue and then the output register before it shows on m_.
// when the receiver stalls, the output byte holds, the back end stops,
// the queue fills and s_ready drops. reset clears the running checksum,
// the open-message flag, the queue and the output valid flag.
module radio_frame_serializer #(
    parameter int PREAMBLE_LEN = rfs_pkg::PREAMBLE_LEN_DEF,
    parameter int QUEUE_DEPTH  = rfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_data_byte,
    input  logic [1:0] s_msg_type,
    input  logic [2:0] s_addr_mask,
    input  logic       s_has_param0,
    input  logic       s_has_param1,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_last
);

    rfs_pkg::job_t          push_job;
    rfs_pkg::job_t          head_job;
    rfs_pkg::queue_status_t q_stat;
    logic                   push;
    logic                   pop;
    logic                   back_busy;
    logic                   s_accept;

    assign s_ready  = !q_stat.full;
    assign s_accept = s_valid && s_ready;

    rfs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .cmd        (s_cmd),
        .data_byte  (s_data_byte),
        .msg_type   (s_msg_type),
        .addr_mask  (s_addr_mask),
        .has_param0 (s_has_param0),
        .has_param1 (s_has_param1),
        .push       (push),
        .job        (push_job)
    );

    rfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_stat)
    );

    rfs_back #(
        .PREAMBLE_LEN (PREAMBLE_LEN)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (!q_stat.empty),
        .job          (head_job),
        .pop          (pop),
        .busy         (back_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last       (m_last)
    );

    a_queue_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    a_idle_back: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.empty |-> !back_busy)
        else $error("back end mid-job with no job queued");

endmodule

>>> rtl/rfs_front.sv
module rfs_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [1:0]           cmd,
    input  logic [7:0]           data_byte,
    input  logic [1:0]           msg_type,
    input  logic [2:0]           addr_mask,
    input  logic                 has_param0,
    input  logic                 has_param1,
    output logic                 push,
    output rfs_pkg::job_t        job
);

    logic [7:0] running_sum_reg, running_sum_next;
    logic       in_message_reg, in_message_next;
    logic [7:0] header;
    logic [7:0] sum_add;

    function automatic logic [7:0] make_header(
        input logic [1:0] mtype,
        input logic [2:0] mask,
        input logic       p0,
        input logic       p1
    );
        logic [1:0] code;
        logic       ok;
        code = 2'd0;
        ok   = 1'b1;
        case (mask)
            3'd7: code = 2'd0;
            3'd4: code = 2'd1;
            3'd5: code = 2'd2;
            3'd3: code = 2'd3;
            default: ok = 1'b0;
        endcase
        return ok ? {2'b00, mtype, code, p0, p1} : rfs_pkg::BAD_HEADER;
    endfunction

    assign header  = make_header(msg_type, addr_mask, has_param0, has_param1);
    assign sum_add = running_sum_reg + data_byte;

    always_comb begin
        running_sum_next = running_sum_reg;
        in_message_next  = in_message_reg;
        push             = 1'b0;
        job.kind         = rfs_pkg::KIND_BODY;
        job.data         = data_byte;
        job.csum         = 8'd0 - sum_add;
        if (accept) begin
            case (cmd)
                rfs_pkg::CMD_START: begin
                    push             = 1'b1;
                    job.kind         = rfs_pkg::KIND_START;
                    job.data         = header;
                    running_sum_next = header;
                    in_message_next  = 1'b1;
                end
                rfs_pkg::CMD_BODY: begin
                    if (in_message_reg) begin
                        push             = 1'b1;
                        running_sum_next = sum_add;
                    end
                end
                rfs_pkg::CMD_FINAL: begin
                    if (in_message_reg) begin
                        push             = 1'b1;
                        job.kind         = rfs_pkg::KIND_FINAL;
                        running_sum_next = 8'd0;
                        in_message_next  = 1'b0;
                    end
                end
                default: begin
                    // undefined command is dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= 8'd0;
            in_message_reg  <= 1'b0;
        end else begin
            running_sum_reg <= running_sum_next;
            in_message_reg  <= in_message_next;
        end
    end

endmodule

>>> rtl/rfs_queue.sv
module rfs_queue #(
    parameter int DEPTH = rfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rfs_pkg::job_t          push_job,
    input  logic                   pop,
    output rfs_pkg::job_t          head_job,
    output rfs_pkg::queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rfs_pkg::job_t slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/rfs_back.sv
module rfs_back #(
    parameter int PREAMBLE_LEN = rfs_pkg::PREAMBLE_LEN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    input  rfs_pkg::job_t job,
    output logic          pop,
    output logic          busy,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_frame_byte,
    output logic          m_last
);

    localparam int SW = $clog2(PREAMBLE_LEN + 7);

    logic [SW-1:0] step_reg, step_next;
    logic [SW-1:0] last_step;
    logic [SW-1:0] rel;
    logic          load, advance, at_last;
    logic [7:0]    byte_sel;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_frame_byte_reg;
    logic          m_last_reg;

    assign load    = !m_valid_reg || m_ready;
    assign advance = load && job_valid;
    assign rel     = step_reg - SW'(PREAMBLE_LEN);

    always_comb begin
        case (job.kind)
            rfs_pkg::KIND_START: last_step = SW'(PREAMBLE_LEN + 6);
            rfs_pkg::KIND_FINAL: last_step = SW'(5);
            default:             last_step = SW'(1);
        endcase
    end

    assign at_last = (step_reg == last_step);
    assign pop     = advance && at_last;
    assign busy    = (step_reg != '0);

    always_comb begin
        byte_sel = rfs_pkg::PREAMBLE_BYTE;
        case (job.kind)
            rfs_pkg::KIND_START: begin
                if (step_reg < SW'(PREAMBLE_LEN)) begin
                    byte_sel = rfs_pkg::PREAMBLE_BYTE;
                end else begin
                    case (rel[2:0])
                        3'd0:    byte_sel = rfs_pkg::SYNC0;
                        3'd1:    byte_sel = rfs_pkg::SYNC1;
                        3'd2:    byte_sel = rfs_pkg::SYNC2;
                        3'd3:    byte_sel = rfs_pkg::SYNC3;
                        3'd4:    byte_sel = rfs_pkg::SYNC4;
                        3'd5:    byte_sel = rfs_pkg::nib_code(job.data[7:4]);
                        3'd6:    byte_sel = rfs_pkg::nib_code(job.data[3:0]);
                        default: byte_sel = rfs_pkg::PREAMBLE_BYTE;
                    endcase
                end
            end
            rfs_pkg::KIND_FINAL: begin
                case (step_reg[2:0])
                    3'd0:    byte_sel = rfs_pkg::nib_code(job.data[7:4]);
                    3'd1:    byte_sel = rfs_pkg::nib_code(job.data[3:0]);
                    3'd2:    byte_sel = rfs_pkg::nib_code(job.csum[7:4]);
                    3'd3:    byte_sel = rfs_pkg::nib_code(job.csum[3:0]);
                    3'd4:    byte_sel = rfs_pkg::TRAILER0;
                    default: byte_sel = rfs_pkg::TRAILER1;
                endcase
            end
            default: begin
                byte_sel = step_reg[0] ? rfs_pkg::nib_code(job.data[3:0])
                                       : rfs_pkg::nib_code(job.data[7:4]);
            end
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = job_valid;
        end
        if (advance) begin
            step_next = at_last ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_frame_byte_reg <= byte_sel;
            m_last_reg       <= at_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_last       = m_last_reg;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int PREAMBLE_LEN = rfs_pkg::PREAMBLE_LEN_DEF;
    localparam logic [1:0] CMD_UNDEF = 2'd3;
    localparam int RANDOM_TARGET = 330;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [7:0] frame_byte;
        logic       last;
    } frame_beat_t;

    // predicts the frame bytes of each request and checks the output stream
    class frame_byte_checker;
        frame_beat_t expected_bytes[$];
        logic [7:0]  msg_sum;
        bit          open_msg;
        int          errors;
        int          checked;
        int          frames;
        int          bad_headers;
        int          abandoned;
        int          ignored;
        logic [7:0]  nib_table[16] = '{
            8'hAA, 8'hA9, 8'hA6, 8'hA5, 8'h9A, 8'h99, 8'h96, 8'h95,
            8'h6A, 8'h69, 8'h66, 8'h65, 8'h5A, 8'h59, 8'h56, 8'h55
        };

        function void push_byte(logic [7:0] b);
            frame_beat_t beat;
            beat.frame_byte = b;
            beat.last = 1'b0;
            expected_bytes.insert(expected_bytes.size(), beat);
        endfunction

        function void push_coded(logic [7:0] b);
            push_byte(nib_table[b[7:4]]);
            push_byte(nib_table[b[3:0]]);
        endfunction

        function logic [7:0] header_of(logic [1:0] mtype, logic [2:0] mask, logic p0,
                                       logic p1);
            logic [1:0] code;
            case (mask)
                3'd7: code = 2'd0;
                3'd4: code = 2'd1;
                3'd5: code = 2'd2;
                3'd3: code = 2'd3;
                default: return rfs_pkg::BAD_HEADER;
            endcase
            return {2'b00, mtype, code, p0, p1};
        endfunction

        // returns the number of frame bytes the request causes
        function int note_request(logic [1:0] cmd, logic [7:0] data, logic [1:0] mtype,
                                  logic [2:0] mask, logic p0, logic p1);
            int n0;
            logic [7:0] hdr;
            n0 = expected_bytes.size();
            case (cmd)
                rfs_pkg::CMD_START: begin
                    hdr = header_of(mtype, mask, p0, p1);
                    if (hdr == rfs_pkg::BAD_HEADER) bad_headers++;
                    if (open_msg) abandoned++;
                    repeat (PREAMBLE_LEN) push_byte(rfs_pkg::PREAMBLE_BYTE);
                    push_byte(rfs_pkg::SYNC0);
                    push_byte(rfs_pkg::SYNC1);
                    push_byte(rfs_pkg::SYNC2);
                    push_byte(rfs_pkg::SYNC3);
                    push_byte(rfs_pkg::SYNC4);
                    push_coded(hdr);
                    msg_sum = hdr;
                    open_msg = 1'b1;
                end
                rfs_pkg::CMD_BODY, rfs_pkg::CMD_FINAL: begin
                    if (!open_msg) begin
                        ignored++;
                        return 0;
                    end
                    msg_sum = msg_sum + data;
                    push_coded(data);
                    if (cmd == rfs_pkg::CMD_FINAL) begin
                        push_coded(8'h00 - msg_sum);
                        push_byte(rfs_pkg::TRAILER0);
                        push_byte(rfs_pkg::TRAILER1);
                        open_msg = 1'b0;
                        msg_sum = 8'h00;
                        frames++;
                    end
                end
                default: begin
                    ignored++;
                    return 0;
                end
            endcase
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
            return expected_bytes.size() - n0;
        endfunction

        function void check_byte(logic [7:0] fb, logic lst);
            frame_beat_t exp_beat;
            if (expected_bytes.size() == 0) begin
                $error("unexpected frame byte %02h last %0b", fb, lst);
                errors++;
                return;
            end
            exp_beat = expected_bytes.pop_front();
            checked++;
            if (fb !== exp_beat.frame_byte) begin
                $error("frame_byte: expected %02h, actual %02h", exp_beat.frame_byte, fb);
                errors++;
            end
            if (lst !== exp_beat.last) begin
                $error("last: expected %0b, actual %0b", exp_beat.last, lst);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_cmd;
    logic [7:0] s_data_byte;
    logic [1:0] s_msg_type;
    logic [2:0] s_addr_mask;
    logic       s_has_param0;
    logic       s_has_param1;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_frame_byte;
    logic       m_last;

    frame_byte_checker sb = new;
    bit calm;
    int busy_items;
    int msgs;

    radio_frame_serializer #(
        .PREAMBLE_LEN(PREAMBLE_LEN)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_data_byte(s_data_byte),
        .s_msg_type(s_msg_type),
        .s_addr_mask(s_addr_mask),
        .s_has_param0(s_has_param0),
        .s_has_param1(s_has_param1),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_frame_byte(m_frame_byte),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(40_000_000);
        $display("tb_top: FAIL");
        $finish;
    end

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_byte(m_frame_byte, m_last);
    end

    initial begin
        int burst;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            burst = $urandom_range(1, 30);
            m_ready <= 1'b1;
            repeat (burst) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] data,
                                input logic [1:0] mtype, input logic [2:0] mask,
                                input logic p0, input logic p1);
        int gap;
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_data_byte <= data;
        s_msg_type <= mtype;
        s_addr_mask <= mask;
        s_has_param0 <= p0;
        s_has_param1 <= p1;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_request(cmd, data, mtype, mask, p0, p1) > 0) busy_items++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // body-type request with random don't-care header fields
    task automatic send_body(input logic [1:0] cmd, input logic [7:0] data);
        send_request(cmd, data, 2'($urandom), 3'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic send_start(input logic [1:0] mtype, input logic [2:0] mask,
                              input logic p0, input logic p1);
        send_request(rfs_pkg::CMD_START, 8'($urandom), mtype, mask, p0, p1);
    endtask

    task automatic send_random_message();
        logic [2:0] good_masks[4] = '{3'd7, 3'd4, 3'd5, 3'd3};
        logic [2:0] mask;
        int n_body;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) send_body(rfs_pkg::CMD_BODY, 8'($urandom));
        else if (r < 10) send_body(rfs_pkg::CMD_FINAL, 8'($urandom));
        else if (r < 13) send_body(CMD_UNDEF, 8'($urandom));
        if ($urandom_range(0, 99) < 80) mask = good_masks[$urandom_range(0, 3)];
        else mask = 3'($urandom);
        send_start(2'($urandom), mask, 1'($urandom), 1'($urandom));
        n_body = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 7);
        repeat (n_body) begin
            if ($urandom_range(0, 49) == 0) send_body(CMD_UNDEF, 8'($urandom));
            send_body(rfs_pkg::CMD_BODY, 8'($urandom));
        end
        // a few messages are left open and cut off by the next start
        if ($urandom_range(0, 99) >= 8) send_body(rfs_pkg::CMD_FINAL, 8'($urandom));
    endtask

    initial begin
        calm = 1'b0;
        busy_items = 0;
        msgs = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd <= rfs_pkg::CMD_START;
        s_data_byte <= 8'h00;
        s_msg_type <= 2'd0;
        s_addr_mask <= 3'd0;
        s_has_param0 <= 1'b0;
        s_has_param1 <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // body requests and an undefined command before any message
        send_body(rfs_pkg::CMD_BODY, 8'hA5);
        send_body(rfs_pkg::CMD_FINAL, 8'h3C);
        send_body(CMD_UNDEF, 8'h00);
        send_start(2'd0, 3'd7, 1'b0, 1'b0);
        send_body(rfs_pkg::CMD_BODY, 8'h00);
        send_body(rfs_pkg::CMD_BODY, 8'hFF);
        send_body(rfs_pkg::CMD_FINAL, 8'h80);
        send_start(2'd1, 3'd4, 1'b1, 1'b0);
        send_body(rfs_pkg::CMD_FINAL, 8'h01);
        send_start(2'd2, 3'd5, 1'b0, 1'b1);
        send_body(rfs_pkg::CMD_BODY, 8'h7F);
        send_body(CMD_UNDEF, 8'hFF);
        // start inside a message drops the open one
        send_start(2'd3, 3'd3, 1'b1, 1'b1);
        send_body(rfs_pkg::CMD_FINAL, 8'hFE);
        // disallowed masks give the bad header, sum wraps to zero here
        send_start(2'd3, 3'd0, 1'b1, 1'b1);
        send_body(rfs_pkg::CMD_FINAL, 8'h01);
        send_start(2'd0, 3'd6, 1'b0, 1'b0);
        send_body(rfs_pkg::CMD_BODY, 8'h12);
        send_start(2'd1, 3'd1, 1'b1, 1'b0);
        send_start(2'd2, 3'd2, 1'b0, 1'b1);
        send_body(rfs_pkg::CMD_FINAL, 8'hFF);

        while (busy_items < RANDOM_TARGET) begin
            if (msgs % 12 == 0) calm = ($urandom_range(0, 3) == 0);
            if (msgs == 20) begin
                // hold the sender until the frame stream has fully drained
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge aclk);
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            send_random_message();
            msgs++;
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d complete frames, %0d bad headers, %0d abandoned messages",
                 sb.frames, sb.bad_headers, sb.abandoned);
        $display("checked %0d frame bytes, %0d requests dropped by the block",
                 sb.checked, sb.ignored);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
